FILE: hdl/assert_macros.svh
// Assertion macros used by the RTL top level of the drive power state machine.
// No dependencies; expects a clock named clk and an active-low reset named arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define DPS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define DPS_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/dps_pkg.sv
// Types and constants of the drive power state machine.
// Used by dps_cfg, dps_step and drive_power_state_machine; no dependencies.
package dps_pkg;

	typedef enum logic [2:0] {
		ST_NOTREADY = 3'd0,
		ST_DISABLED = 3'd1,
		ST_READY    = 3'd2,
		ST_SWON     = 3'd3,
		ST_ENABLED  = 3'd4,
		ST_QSTOP    = 3'd5,
		ST_FAULT    = 3'd6
	} state_t;

	// Operation codes of an input transaction.
	localparam logic [2:0] KIND_CTRL_WRITE  = 3'd0;
	localparam logic [2:0] KIND_SPEED_WRITE = 3'd1;
	localparam logic [2:0] KIND_STATUS_READ = 3'd2;
	localparam logic [2:0] KIND_FAULT_TRIP  = 3'd3;
	localparam logic [2:0] KIND_SPEED_READ  = 3'd4;

	// Answer codes.
	localparam logic [1:0] RESP_OK    = 2'd0;
	localparam logic [1:0] RESP_ERROR = 2'd1;
	localparam logic [1:0] RESP_BUSY  = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_SPEED_MODE = 2'd0;
	localparam logic [1:0] CFG_SPEED_LIMIT = 2'd1;
	localparam logic [1:0] CFG_UV_CODE = 2'd2;

	localparam logic [14:0] SPEED_LIMIT_RESET = 15'd8000;
	localparam logic [15:0] UV_CODE_RESET = 16'd1;

	// Control word bit positions.
	localparam int CW_SWITCH_ON  = 0;
	localparam int CW_EN_VOLTAGE = 1;
	localparam int CW_QUICK_STOP = 2;
	localparam int CW_EN_OP      = 3;
	localparam int CW_FAULT_RST  = 7;

	// Status word bit positions.
	localparam int SW_READY     = 0;
	localparam int SW_SWON      = 1;
	localparam int SW_ENABLED   = 2;
	localparam int SW_FAULT     = 3;
	localparam int SW_PRECHARGE = 4;
	localparam int SW_QSTOP     = 5;
	localparam int SW_DISABLED  = 6;
	localparam int SW_REMOTE    = 9;
	localparam int SW_SPEED_OK  = 10;

	typedef struct packed {
		logic        speed_mode_on;
		logic [14:0] speed_limit;
		logic [15:0] undervoltage_code;
	} cfg_t;

	typedef struct packed {
		state_t      drive_state;
		logic [15:0] error_code;
		logic [15:0] speed_target;
		logic        output_enabled;
	} drive_regs_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] value;
		logic [15:0] actual_speed;
		logic        precharge_done;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] read_data;
		logic [2:0]  drive_state_out;
		logic        power_stage_on;
	} result_t;

endpackage

FILE: hdl/dps_cfg.sv
// Configuration register bank of the drive power state machine.
// Depends on dps_pkg for the register indexes, reset values and cfg_t.
module dps_cfg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [1:0]       wr_index,
	input  logic [15:0]      wr_data,
	output dps_pkg::cfg_t    cfg
);

	dps_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.speed_mode_on     <= 1'b0;
			cfg_q.speed_limit       <= dps_pkg::SPEED_LIMIT_RESET;
			cfg_q.undervoltage_code <= dps_pkg::UV_CODE_RESET;
		end else if (wr_en) begin
			case (wr_index)
				dps_pkg::CFG_SPEED_MODE:  cfg_q.speed_mode_on     <= wr_data[0];
				dps_pkg::CFG_SPEED_LIMIT: cfg_q.speed_limit       <= wr_data[14:0];
				dps_pkg::CFG_UV_CODE:     cfg_q.undervoltage_code <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hdl/dps_step.sv
// Combinational step logic: next drive state and the answer for one transaction.
// Depends on dps_pkg for the state type, operation codes and structs.
module dps_step (
	input  dps_pkg::drive_regs_t regs,
	input  dps_pkg::cfg_t        cfg,
	input  dps_pkg::item_t       item,
	output dps_pkg::drive_regs_t regs_next,
	output dps_pkg::result_t     result
);

	logic b0, b1, b2, b3, b7;
	dps_pkg::drive_regs_t cw_regs;
	dps_pkg::state_t s;

	logic signed [16:0] sp17;
	logic signed [16:0] act17;
	logic signed [16:0] diff;
	logic signed [19:0] diff20;
	logic signed [19:0] d5;
	logic signed [19:0] sp20;
	logic signed [19:0] neg_sp20;
	logic               speed_ok;
	logic [15:0]        status_word;

	logic signed [16:0] val17;
	logic signed [16:0] lim17;
	logic               speed_reject;

	assign b0 = item.value[dps_pkg::CW_SWITCH_ON];
	assign b1 = item.value[dps_pkg::CW_EN_VOLTAGE];
	assign b2 = item.value[dps_pkg::CW_QUICK_STOP];
	assign b3 = item.value[dps_pkg::CW_EN_OP];
	assign b7 = item.value[dps_pkg::CW_FAULT_RST];

	// The transition checks run in order, each seeing the state left by the last.
	always_comb begin
		cw_regs = regs;
		s = regs.drive_state;
		if (!b1) begin
			cw_regs.output_enabled = 1'b0;
			if (s != dps_pkg::ST_FAULT) s = dps_pkg::ST_DISABLED;
		end
		if (b1 && b2 && s == dps_pkg::ST_DISABLED) begin
			if (item.precharge_done) begin
				s = dps_pkg::ST_READY;
			end else begin
				cw_regs.error_code = cfg.undervoltage_code;
				s = dps_pkg::ST_FAULT;
				cw_regs.output_enabled = 1'b0;
			end
		end
		if (b0 && b2 && s == dps_pkg::ST_READY) s = dps_pkg::ST_SWON;
		if (!b0 && b2 && (s == dps_pkg::ST_SWON || s == dps_pkg::ST_ENABLED ||
				s == dps_pkg::ST_QSTOP)) begin
			s = dps_pkg::ST_READY;
			cw_regs.output_enabled = 1'b0;
		end
		if (!b2 && s == dps_pkg::ST_ENABLED) begin
			cw_regs.output_enabled = 1'b0;
			s = dps_pkg::ST_QSTOP;
		end
		if (b3 && b2 && b1 && b0 && (s == dps_pkg::ST_SWON || s == dps_pkg::ST_QSTOP)) begin
			cw_regs.output_enabled = 1'b1;
			s = dps_pkg::ST_ENABLED;
		end
		if (!b3 && b2 && b1 && b0 && s == dps_pkg::ST_ENABLED) begin
			cw_regs.output_enabled = 1'b0;
			s = dps_pkg::ST_SWON;
		end
		if (b7 && s == dps_pkg::ST_FAULT) begin
			cw_regs.error_code = 16'd0;
			s = dps_pkg::ST_DISABLED;
		end
		cw_regs.drive_state = s;
	end

	// Speed reached in speed mode: five times the error stays strictly inside +/- target.
	assign sp17     = $signed({regs.speed_target[15], regs.speed_target});
	assign act17    = $signed({item.actual_speed[15], item.actual_speed});
	assign diff     = sp17 - act17;
	assign diff20   = $signed({{3{diff[16]}}, diff});
	assign d5       = (diff20 <<< 2) + diff20;
	assign sp20     = $signed({{3{sp17[16]}}, sp17});
	assign neg_sp20 = -sp20;
	assign speed_ok = cfg.speed_mode_on && !(d5 >= sp20 || d5 <= neg_sp20);

	always_comb begin
		status_word = 16'd0;
		status_word[dps_pkg::SW_READY] = regs.drive_state == dps_pkg::ST_READY ||
			regs.drive_state == dps_pkg::ST_SWON || regs.drive_state == dps_pkg::ST_ENABLED ||
			regs.drive_state == dps_pkg::ST_QSTOP;
		status_word[dps_pkg::SW_SWON] = regs.drive_state == dps_pkg::ST_SWON ||
			regs.drive_state == dps_pkg::ST_ENABLED || regs.drive_state == dps_pkg::ST_QSTOP;
		status_word[dps_pkg::SW_ENABLED] = regs.drive_state == dps_pkg::ST_ENABLED ||
			regs.drive_state == dps_pkg::ST_QSTOP;
		status_word[dps_pkg::SW_FAULT]     = regs.error_code != 16'd0;
		status_word[dps_pkg::SW_PRECHARGE] = item.precharge_done;
		status_word[dps_pkg::SW_QSTOP]     = regs.drive_state == dps_pkg::ST_QSTOP;
		status_word[dps_pkg::SW_DISABLED]  = regs.drive_state == dps_pkg::ST_DISABLED;
		status_word[dps_pkg::SW_REMOTE]    = 1'b1;
		status_word[dps_pkg::SW_SPEED_OK]  = speed_ok;
	end

	assign val17 = $signed({item.value[15], item.value});
	assign lim17 = $signed({2'b00, cfg.speed_limit});
	assign speed_reject = val17 > lim17 || val17 < -lim17 || !cfg.speed_mode_on;

	always_comb begin
		regs_next = regs;
		result.status = dps_pkg::RESP_OK;
		result.read_data = 16'd0;
		case (item.kind)
			dps_pkg::KIND_CTRL_WRITE: begin
				regs_next = cw_regs;
			end
			dps_pkg::KIND_SPEED_WRITE: begin
				if (speed_reject) result.status = dps_pkg::RESP_BUSY;
				else regs_next.speed_target = item.value;
			end
			dps_pkg::KIND_STATUS_READ: begin
				result.read_data = status_word;
			end
			dps_pkg::KIND_FAULT_TRIP: begin
				regs_next.error_code = item.value;
				regs_next.drive_state = dps_pkg::ST_FAULT;
				regs_next.output_enabled = 1'b0;
			end
			dps_pkg::KIND_SPEED_READ: begin
				result.read_data = regs.speed_target;
			end
			default: begin
				result.status = dps_pkg::RESP_ERROR;
			end
		endcase
		result.drive_state_out = regs_next.drive_state;
		result.power_stage_on = regs_next.output_enabled;
	end

endmodule

FILE: hdl/drive_power_state_machine.sv
// Drive power state machine in the style of the CiA 402 control and status words.
// Input channel (in_valid / in_stall): one transaction carries kind, value,
// actual_speed and precharge_done; it is taken when in_valid is high and in_stall low.
// Output channel (out_valid / out_stall): one answer per input transaction, in order,
// with status, read_data, drive_state_out and power_stage_on.
// Configuration channel (cfg_valid / cfg_ready): cfg_index selects speed_mode_on,
// speed_limit or undervoltage_code; cfg_ready is always high. Write only when idle.
// The input register takes a transaction and the output register loads its answer from
// the step logic. One transaction per cycle while the receiver does not stall, set by the
// single input register feeding the step logic and the output register.
// Reset (arst_n low) puts the drive in switch-on-disabled, clears the error code,
// the speed target and the power stage enable, and loads the register defaults.
// When the receiver stalls, the answer holds in the output register; one further
// transaction is taken into the input register, after which in_stall rises until
// the output is taken.
// Depends on dps_pkg, dps_cfg, dps_step and assert_macros.svh.
`include "assert_macros.svh"

module drive_power_state_machine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  kind,
	input  logic [15:0] value,
	input  logic signed [15:0] actual_speed,
	input  logic        precharge_done,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [15:0] read_data,
	output logic [2:0]  drive_state_out,
	output logic        power_stage_on,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	dps_pkg::cfg_t        cfg;
	dps_pkg::item_t       item_s1;
	logic                 valid_s1;
	dps_pkg::drive_regs_t regs_q;
	dps_pkg::drive_regs_t regs_next;
	dps_pkg::result_t     result;
	dps_pkg::result_t     result_s2;
	logic                 valid_s2;
	logic                 advance;
	logic                 in_take;

	// Registers are always ready to take a configuration write.
	assign cfg_ready = 1'b1;

	dps_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// The input register moves on whenever the output register is empty or being taken.
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && valid_s2 && out_stall;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.kind           <= kind;
			item_s1.value          <= value;
			item_s1.actual_speed   <= actual_speed;
			item_s1.precharge_done <= precharge_done;
		end
	end

	dps_step u_step (
		.regs      (regs_q),
		.cfg       (cfg),
		.item      (item_s1),
		.regs_next (regs_next),
		.result    (result)
	);

	// Drive state is committed at the same edge that loads the answer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.drive_state    <= dps_pkg::ST_DISABLED;
			regs_q.error_code     <= 16'd0;
			regs_q.speed_target   <= 16'd0;
			regs_q.output_enabled <= 1'b0;
			valid_s2              <= 1'b0;
		end else if (advance) begin
			regs_q   <= regs_next;
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign out_valid       = valid_s2;
	assign status          = result_s2.status;
	assign read_data       = result_s2.read_data;
	assign drive_state_out = result_s2.drive_state_out;
	assign power_stage_on  = result_s2.power_stage_on;

	// The power stage is on exactly when the drive is in operation enabled.
	`DPS_ASSERT(a_stage_matches_state, (regs_q.output_enabled == (regs_q.drive_state == dps_pkg::ST_ENABLED)), "power stage enable disagrees with drive state")
	// Input is held back only while both pipeline registers are full.
	`DPS_ASSERT_ALWAYS(a_stall_only_when_full, (in_stall |-> (valid_s1 && valid_s2 && out_stall)), "input stalled with room in the pipeline")
	// Drive state changes only when a transaction passes through the step logic.
	`DPS_ASSERT(a_state_only_on_advance, (!advance |=> $stable(regs_q)), "drive state changed without a transaction")
	// The drive never enters the not-ready state after reset.
	`DPS_ASSERT(a_never_notready, (regs_q.drive_state != dps_pkg::ST_NOTREADY), "drive reached not ready")

endmodule

FILE: tb/tb_drive_power_state_machine.sv
// Self-checking testbench for the drive power state machine: a directed table, then random traffic.
// A predictor written in SystemVerilog forecasts every answer, and the answers are checked in order.
// Depends on dps_pkg and the drive_power_state_machine RTL only.
`timescale 1ns / 1ps

module tb_drive_power_state_machine;

	// The package names only the five operations; the three spare encodings answer with an error.
	localparam logic [2:0] KIND_RSVD_5 = 3'd5;
	localparam logic [2:0] KIND_RSVD_7 = 3'd7;

	// Common control words, built from the CiA 402 command bits.
	localparam logic [15:0] CMD_DISABLE_VOLT = 16'h0000;
	localparam logic [15:0] CMD_QUICK_STOP   = 16'h0002;
	localparam logic [15:0] CMD_SHUTDOWN     = 16'h0006;
	localparam logic [15:0] CMD_SWITCH_ON    = 16'h0007;
	localparam logic [15:0] CMD_ENABLE_OP    = 16'h000F;
	localparam logic [15:0] CMD_FAULT_RESET  = 16'h0080;
	// Bits that none of the transition checks look at, used to add noise to control words.
	localparam logic [15:0] CW_DONT_CARE     = 16'hFF70;

	// Status word straight after reset: switch-on disabled and remote, nothing else.
	localparam logic [15:0] WORD_AFTER_RESET = 16'h0240;

	localparam int MAX_IDLE        = 12;
	localparam int NUM_PHASES      = 8;
	localparam int ITEMS_PER_PHASE = 210;
	localparam int PRESSURE_PHASE  = 2;
	localparam int PRESSURE_HOLD   = 80;
	localparam int CYCLE_LIMIT     = 500000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [2:0]         kind;
	logic [15:0]        value;
	logic signed [15:0] actual_speed;
	logic               precharge_done;
	logic               out_valid;
	logic               out_stall;
	logic [1:0]         status;
	logic [15:0]        read_data;
	logic [2:0]         drive_state_out;
	logic               power_stage_on;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [15:0]        cfg_data;

	drive_power_state_machine uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.kind           (kind),
		.value          (value),
		.actual_speed   (actual_speed),
		.precharge_done (precharge_done),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.read_data      (read_data),
		.drive_state_out(drive_state_out),
		.power_stage_on (power_stage_on),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	// One row of the directed table: either a register write or a command transaction.
	// A command row may carry a hand-written answer, which then replaces the forecast one.
	typedef struct {
		logic             is_reg;
		logic [1:0]       reg_idx;
		logic [15:0]      reg_data;
		dps_pkg::item_t   cmd;
		logic             pinned;
		dps_pkg::result_t ans;
	} plan_row_t;

	plan_row_t        plan[$];
	dps_pkg::result_t answers_due[$];

	// Forecast copy of the drive: its state and its configuration registers.
	dps_pkg::state_t drv_state;
	logic [15:0]     fault_code;
	logic [15:0]     target_speed;
	logic            stage_on;
	logic            mode_on;
	logic [14:0]     limit_rpm;
	logic [15:0]     uv_code;

	// Set by the stimulus alongside each payload, so that the monitor knows about typed answers.
	logic             pin_on;
	dps_pkg::result_t pin_ans;

	// Idling controls, changed phase by phase by the stimulus process.
	logic send_idle;
	logic recv_idle;
	int   long_hold;

	int          mismatches = 0;
	int unsigned cycles_run = 0;

	// The clock runs freely with a 10 ns period.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// A hung handshake would otherwise run forever, so the run is cut off at a generous limit.
	always @(posedge clk) begin
		cycles_run <= cycles_run + 1;
		if (cycles_run == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic logic [15:0] rand16();
		logic [31:0] r;
		r = $urandom;
		return r[15:0];
	endfunction

	// Works out the answer to one command transaction and moves the forecast state on.
	// A control word runs the eight transition checks in order, each seeing the state that
	// the previous one left behind, so the state is carried in a local until the end.
	function automatic dps_pkg::result_t drive_response(input dps_pkg::item_t it);
		dps_pkg::result_t r;
		dps_pkg::state_t  s;
		logic             b0, b1, b2, b3, b7;
		logic [15:0]      w;
		int               req, act, d5, lim;
		r.status = dps_pkg::RESP_OK;
		r.read_data = '0;
		case (it.kind)
			dps_pkg::KIND_CTRL_WRITE: begin
				b0 = it.value[dps_pkg::CW_SWITCH_ON];
				b1 = it.value[dps_pkg::CW_EN_VOLTAGE];
				b2 = it.value[dps_pkg::CW_QUICK_STOP];
				b3 = it.value[dps_pkg::CW_EN_OP];
				b7 = it.value[dps_pkg::CW_FAULT_RST];
				s = drv_state;
				// Voltage disable: the power stage goes off; a fault is kept.
				if (!b1) begin
					stage_on = 1'b0;
					if (s != dps_pkg::ST_FAULT)
						s = dps_pkg::ST_DISABLED;
				end
				// Enable voltage: without a finished precharge this trips on undervoltage.
				if (b1 && b2 && s == dps_pkg::ST_DISABLED) begin
					if (it.precharge_done) begin
						s = dps_pkg::ST_READY;
					end else begin
						fault_code = uv_code;
						s = dps_pkg::ST_FAULT;
						stage_on = 1'b0;
					end
				end
				if (b0 && b2 && s == dps_pkg::ST_READY)
					s = dps_pkg::ST_SWON;
				if (!b0 && b2 && (s == dps_pkg::ST_SWON || s == dps_pkg::ST_ENABLED ||
						s == dps_pkg::ST_QSTOP)) begin
					s = dps_pkg::ST_READY;
					stage_on = 1'b0;
				end
				if (!b2 && s == dps_pkg::ST_ENABLED) begin
					stage_on = 1'b0;
					s = dps_pkg::ST_QSTOP;
				end
				if (b3 && b2 && b1 && b0 &&
						(s == dps_pkg::ST_SWON || s == dps_pkg::ST_QSTOP)) begin
					stage_on = 1'b1;
					s = dps_pkg::ST_ENABLED;
				end
				if (!b3 && b2 && b1 && b0 && s == dps_pkg::ST_ENABLED) begin
					stage_on = 1'b0;
					s = dps_pkg::ST_SWON;
				end
				if (b7 && s == dps_pkg::ST_FAULT) begin
					fault_code = '0;
					s = dps_pkg::ST_DISABLED;
				end
				drv_state = s;
			end
			dps_pkg::KIND_SPEED_WRITE: begin
				req = $signed(it.value);
				lim = limit_rpm;
				if (!mode_on || req > lim || req < -lim)
					r.status = dps_pkg::RESP_BUSY;
				else
					target_speed = it.value;
			end
			dps_pkg::KIND_STATUS_READ: begin
				w = '0;
				w[dps_pkg::SW_READY] = (drv_state >= dps_pkg::ST_READY) &&
					(drv_state <= dps_pkg::ST_QSTOP);
				w[dps_pkg::SW_SWON] = (drv_state == dps_pkg::ST_SWON) ||
					(drv_state == dps_pkg::ST_ENABLED) || (drv_state == dps_pkg::ST_QSTOP);
				w[dps_pkg::SW_ENABLED] = (drv_state == dps_pkg::ST_ENABLED) ||
					(drv_state == dps_pkg::ST_QSTOP);
				w[dps_pkg::SW_FAULT] = (fault_code != '0);
				w[dps_pkg::SW_PRECHARGE] = it.precharge_done;
				w[dps_pkg::SW_QSTOP] = (drv_state == dps_pkg::ST_QSTOP);
				w[dps_pkg::SW_DISABLED] = (drv_state == dps_pkg::ST_DISABLED);
				w[dps_pkg::SW_REMOTE] = 1'b1;
				// Speed reached: the error, five times over, lies strictly between the
				// target and its negation. Only reported in closed-loop speed mode.
				if (mode_on) begin
					req = $signed(target_speed);
					act = $signed(it.actual_speed);
					d5 = (req - act) * 5;
					w[dps_pkg::SW_SPEED_OK] = !(d5 >= req || d5 <= -req);
				end
				r.read_data = w;
			end
			dps_pkg::KIND_FAULT_TRIP: begin
				fault_code = it.value;
				drv_state = dps_pkg::ST_FAULT;
				stage_on = 1'b0;
			end
			dps_pkg::KIND_SPEED_READ: r.read_data = target_speed;
			default: r.status = dps_pkg::RESP_ERROR;
		endcase
		r.drive_state_out = drv_state;
		r.power_stage_on = stage_on;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want_v,
		input logic [15:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
			mismatches++;
		end
	endtask

	// Monitor. Everything is sampled at the rising edge, before the RTL's registers move, so
	// a transaction counts exactly when valid is high and stall low. The answer leaving on an
	// edge always belongs to an earlier command, so it is checked before the new forecast.
	always @(posedge clk) begin : watch_ports
		dps_pkg::item_t   seen;
		dps_pkg::result_t want, got;
		if (!arst_n) begin
			drv_state = dps_pkg::ST_DISABLED;
			fault_code = '0;
			target_speed = '0;
			stage_on = 1'b0;
			mode_on = 1'b0;
			limit_rpm = dps_pkg::SPEED_LIMIT_RESET;
			uv_code = dps_pkg::UV_CODE_RESET;
		end else begin
			if (out_valid && !out_stall) begin
				got.status = status;
				got.read_data = read_data;
				got.drive_state_out = drive_state_out;
				got.power_stage_on = power_stage_on;
				if (answers_due.size() == 0) begin
					$display("%0t ns: unexpected answer, expected none, actual %0h",
						$time, got);
					mismatches++;
				end else begin
					want = answers_due.pop_front();
					check_field("status", 16'(want.status), 16'(got.status));
					check_field("read_data", want.read_data, got.read_data);
					check_field("drive_state_out", 16'(want.drive_state_out),
						16'(got.drive_state_out));
					check_field("power_stage_on", 16'(want.power_stage_on),
						16'(got.power_stage_on));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					dps_pkg::CFG_SPEED_MODE:  mode_on = cfg_data[0];
					dps_pkg::CFG_SPEED_LIMIT: limit_rpm = cfg_data[14:0];
					dps_pkg::CFG_UV_CODE:     uv_code = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				seen.kind = kind;
				seen.value = value;
				seen.actual_speed = actual_speed;
				seen.precharge_done = precharge_done;
				// The forecast always runs so that its state stays in step with the drive.
				want = drive_response(seen);
				if (pin_on)
					want = pin_ans;
				answers_due.push_back(want);
			end
		end
	end

	// Receiver. Before each answer it holds off for a random stretch while receiver idling is on;
	// once during the pressure phase it holds off for a long stretch so that the block backs up.
	initial begin : receiver
		int hold;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			hold = recv_idle ? $urandom_range(0, MAX_IDLE) : 0;
			if (long_hold > 0) begin
				hold = long_hold;
				long_hold = 0;
			end
			if (hold > 0) begin
				out_stall = 1'b1;
				repeat (hold) @(negedge clk);
				out_stall = 1'b0;
			end
			do @(posedge clk); while (!out_valid);
		end
	end

	// Offers one command transaction, after an optional gap, and returns at the falling edge
	// after it has been taken. Valid is left high so that a following command needs no gap.
	task automatic send_command(input dps_pkg::item_t it, input logic pinned,
		input dps_pkg::result_t ans);
		int gap;
		gap = send_idle ? $urandom_range(0, MAX_IDLE) : 0;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		kind = it.kind;
		value = it.value;
		actual_speed = it.actual_speed;
		precharge_done = it.precharge_done;
		pin_on = pinned;
		pin_ans = ans;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// Drops valid and waits until every answer in flight has come back.
	task automatic wait_idle();
		in_valid = 1'b0;
		while (answers_due.size() != 0) @(negedge clk);
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [15:0] data);
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic plan_row_t cmd_row(logic [2:0] k, logic [15:0] v, logic [15:0] a,
		logic p);
		plan_row_t row;
		row.is_reg = 1'b0;
		row.reg_idx = '0;
		row.reg_data = '0;
		row.cmd.kind = k;
		row.cmd.value = v;
		row.cmd.actual_speed = a;
		row.cmd.precharge_done = p;
		row.pinned = 1'b0;
		row.ans = '0;
		return row;
	endfunction

	function automatic plan_row_t pinned_row(logic [2:0] k, logic [15:0] v, logic [15:0] a,
		logic p, logic [1:0] st, logic [15:0] rd, logic [2:0] ds, logic pw);
		plan_row_t row;
		row = cmd_row(k, v, a, p);
		row.pinned = 1'b1;
		row.ans.status = st;
		row.ans.read_data = rd;
		row.ans.drive_state_out = ds;
		row.ans.power_stage_on = pw;
		return row;
	endfunction

	function automatic plan_row_t reg_row(logic [1:0] idx, logic [15:0] data);
		plan_row_t row;
		row = cmd_row(dps_pkg::KIND_STATUS_READ, '0, '0, 1'b0);
		row.is_reg = 1'b1;
		row.reg_idx = idx;
		row.reg_data = data;
		return row;
	endfunction

	// Control words for random traffic. Most of them are the command that moves the drive
	// one step further along the usual power-up path from where it is now, so that the
	// enabled and quick stop states are reached often; the rest are any command, and a few
	// are pure noise. Half of them get noise in the bits that no check looks at.
	function automatic logic [15:0] pick_control();
		logic [15:0] cw;
		if ($urandom_range(0, 9) == 0)
			return rand16();
		if ($urandom_range(0, 9) < 6) begin
			case (drv_state)
				dps_pkg::ST_DISABLED: cw = CMD_SHUTDOWN;
				dps_pkg::ST_READY:    cw = CMD_SWITCH_ON;
				dps_pkg::ST_SWON:     cw = CMD_ENABLE_OP;
				dps_pkg::ST_ENABLED: begin
					case ($urandom_range(0, 3))
						0:       cw = CMD_QUICK_STOP;
						1:       cw = CMD_SWITCH_ON;
						2:       cw = CMD_SHUTDOWN;
						default: cw = CMD_DISABLE_VOLT;
					endcase
				end
				dps_pkg::ST_QSTOP:
					cw = ($urandom_range(0, 2) != 0) ? CMD_ENABLE_OP : CMD_SHUTDOWN;
				dps_pkg::ST_FAULT:    cw = CMD_FAULT_RESET;
				default:              cw = CMD_SHUTDOWN;
			endcase
		end else begin
			case ($urandom_range(0, 6))
				0:       cw = CMD_DISABLE_VOLT;
				1:       cw = CMD_QUICK_STOP;
				2:       cw = CMD_SHUTDOWN;
				3:       cw = CMD_SWITCH_ON;
				4:       cw = CMD_ENABLE_OP;
				5:       cw = CMD_FAULT_RESET;
				default: cw = CMD_ENABLE_OP | CMD_FAULT_RESET;
			endcase
		end
		if ($urandom_range(0, 1) != 0)
			cw = cw | (rand16() & CW_DONT_CARE);
		return cw;
	endfunction

	// Target speeds cluster on both edges of the accepted range, with some anywhere at all.
	function automatic logic [15:0] pick_speed();
		int lim, v;
		lim = limit_rpm;
		case ($urandom_range(0, 5))
			0:       v = lim;
			1:       v = -lim;
			2:       v = lim + 1;
			3:       v = -lim - 1;
			4:       v = int'($urandom_range(0, 2 * lim)) - lim;
			default: v = $signed(rand16());
		endcase
		return v[15:0];
	endfunction

	function automatic dps_pkg::item_t random_command();
		dps_pkg::item_t it;
		int             sel, tgt, spread, v;
		logic [31:0]    r;
		sel = $urandom_range(0, 99);
		it.value = rand16();
		it.actual_speed = rand16();
		it.precharge_done = ($urandom_range(0, 9) != 0);
		if (sel < 45) begin
			it.kind = dps_pkg::KIND_CTRL_WRITE;
			it.value = pick_control();
		end else if (sel < 57) begin
			it.kind = dps_pkg::KIND_SPEED_WRITE;
			it.value = pick_speed();
		end else if (sel < 75) begin
			it.kind = dps_pkg::KIND_STATUS_READ;
			// Most reads put the measured speed close to the target, so that the
			// speed-reached bit is seen on both sides of its window.
			if ($urandom_range(0, 3) != 0) begin
				tgt = $signed(target_speed);
				spread = ((tgt < 0) ? -tgt : tgt) / 4 + 2;
				v = tgt + int'($urandom_range(0, 2 * spread)) - spread;
				it.actual_speed = v[15:0];
			end
		end else if (sel < 80) begin
			it.kind = dps_pkg::KIND_FAULT_TRIP;
			if ($urandom_range(0, 3) == 0)
				it.value = '0;
		end else if (sel < 90) begin
			it.kind = dps_pkg::KIND_SPEED_READ;
		end else begin
			r = $urandom_range(KIND_RSVD_5, KIND_RSVD_7);
			it.kind = r[2:0];
		end
		return it;
	endfunction

	// Stimulus: reset, the directed table, then random phases, each under its own settings.
	initial begin : stimulus
		int          ph;
		logic        m;
		logic [15:0] lim, uv;
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = dps_pkg::KIND_STATUS_READ;
		value = '0;
		actual_speed = '0;
		precharge_done = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = dps_pkg::CFG_SPEED_MODE;
		cfg_data = '0;
		pin_on = 1'b0;
		pin_ans = '0;
		send_idle = 1'b1;
		recv_idle = 1'b1;
		long_hold = 0;

		// Reset values first, then every operation with the register defaults in place.
		plan.push_back(pinned_row(dps_pkg::KIND_STATUS_READ, '0, '0, 1'b0,
			dps_pkg::RESP_OK, WORD_AFTER_RESET, dps_pkg::ST_DISABLED, 1'b0));
		plan.push_back(pinned_row(dps_pkg::KIND_SPEED_READ, '0, '0, 1'b0,
			dps_pkg::RESP_OK, '0, dps_pkg::ST_DISABLED, 1'b0));
		// Speed mode is off after reset, so even a small target is turned away.
		plan.push_back(pinned_row(dps_pkg::KIND_SPEED_WRITE, 16'd100, '0, 1'b0,
			dps_pkg::RESP_BUSY, '0, dps_pkg::ST_DISABLED, 1'b0));
		plan.push_back(pinned_row(KIND_RSVD_5, '0, '0, 1'b0,
			dps_pkg::RESP_ERROR, '0, dps_pkg::ST_DISABLED, 1'b0));
		plan.push_back(pinned_row(KIND_RSVD_7, 16'hFFFF, 16'h8000, 1'b1,
			dps_pkg::RESP_ERROR, '0, dps_pkg::ST_DISABLED, 1'b0));
		// Enabling the voltage before the DC bus has charged trips on undervoltage.
		plan.push_back(pinned_row(dps_pkg::KIND_CTRL_WRITE, CMD_SHUTDOWN, '0, 1'b0,
			dps_pkg::RESP_OK, '0, dps_pkg::ST_FAULT, 1'b0));
		plan.push_back(cmd_row(dps_pkg::KIND_STATUS_READ, '0, 16'h8000, 1'b1));
		plan.push_back(pinned_row(dps_pkg::KIND_CTRL_WRITE, CMD_FAULT_RESET, '0, 1'b1,
			dps_pkg::RESP_OK, '0, dps_pkg::ST_DISABLED, 1'b0));
		// The normal power-up path, disable operation, quick stop and its recovery.
		plan.push_back(cmd_row(dps_pkg::KIND_CTRL_WRITE, CMD_SHUTDOWN, '0, 1'b1));
		plan.push_back(cmd_row(dps_pkg::KIND_CTRL_WRITE, CMD_SWITCH_ON, '0, 1'b1));
		plan.push_back(cmd_row(dps_pkg::KIND_CTRL_WRITE, CMD_ENABLE_OP, '0, 1'b1));
		plan.push_back(cmd_row(dps_pkg::KIND_CTRL_WRITE, CMD_SWITCH_ON, '0, 1'b1));
		plan.push_back(cmd_row(dps_pkg::KIND_CTRL_WRITE, CMD_ENABLE_OP, '0, 1'b1));
		plan.push_back(cmd_row(dps_pkg::KIND_CTRL_WRITE, 16'h000B, '0, 1'b1));
		plan.push_back(cmd_row(dps_pkg::KIND_STATUS_READ, '0, 16'h7FFF, 1'b1));
		plan.push_back(cmd_row(dps_pkg::KIND_CTRL_WRITE, CMD_ENABLE_OP, '0, 1'b1));
		plan.push_back(cmd_row(dps_pkg::KIND_CTRL_WRITE, 16'h000E, '0, 1'b1));
		// A trip with a zero code still faults, but the status word shows no error.
		plan.push_back(pinned_row(dps_pkg::KIND_FAULT_TRIP, '0, '0, 1'b1,
			dps_pkg::RESP_OK, '0, dps_pkg::ST_FAULT, 1'b0));
		plan.push_back(cmd_row(dps_pkg::KIND_STATUS_READ, '0, '0, 1'b1));
		plan.push_back(cmd_row(dps_pkg::KIND_CTRL_WRITE, CMD_DISABLE_VOLT, '0, 1'b1));
		plan.push_back(cmd_row(dps_pkg::KIND_CTRL_WRITE, 16'hFFFF, '0, 1'b1));
		plan.push_back(pinned_row(dps_pkg::KIND_FAULT_TRIP, 16'hFFFF, '0, 1'b1,
			dps_pkg::RESP_OK, '0, dps_pkg::ST_FAULT, 1'b0));
		// Speed mode on with the widest limit: the most negative target is still outside.
		plan.push_back(reg_row(dps_pkg::CFG_SPEED_MODE, 16'd1));
		plan.push_back(reg_row(dps_pkg::CFG_SPEED_LIMIT, 16'h7FFF));
		plan.push_back(pinned_row(dps_pkg::KIND_SPEED_WRITE, 16'h8000, '0, 1'b1,
			dps_pkg::RESP_BUSY, '0, dps_pkg::ST_FAULT, 1'b0));
		plan.push_back(pinned_row(dps_pkg::KIND_SPEED_WRITE, 16'h7FFF, '0, 1'b1,
			dps_pkg::RESP_OK, '0, dps_pkg::ST_FAULT, 1'b0));
		plan.push_back(pinned_row(dps_pkg::KIND_SPEED_READ, '0, '0, 1'b1,
			dps_pkg::RESP_OK, 16'h7FFF, dps_pkg::ST_FAULT, 1'b0));
		plan.push_back(cmd_row(dps_pkg::KIND_STATUS_READ, '0, '0, 1'b0));
		// A different undervoltage code must be the one that gets stored.
		plan.push_back(reg_row(dps_pkg::CFG_UV_CODE, 16'hFFFF));
		plan.push_back(cmd_row(dps_pkg::KIND_CTRL_WRITE, CMD_FAULT_RESET, '0, 1'b1));
		plan.push_back(cmd_row(dps_pkg::KIND_CTRL_WRITE, CMD_SHUTDOWN, '0, 1'b0));
		plan.push_back(cmd_row(dps_pkg::KIND_STATUS_READ, '0, 16'h7FFF, 1'b0));

		// Reset is released on a falling edge.
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_reg) begin
				wait_idle();
				write_register(plan[i].reg_idx, plan[i].reg_data);
			end else begin
				send_command(plan[i].cmd, plan[i].pinned, plan[i].ans);
			end
		end

		// Random phases: register defaults, both extremes, speed mode off, then random settings.
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: begin
					m = 1'b1;
					lim = 16'd8000;
					uv = 16'd1;
				end
				1: begin
					m = 1'b1;
					lim = '0;
					uv = '0;
				end
				2: begin
					m = 1'b1;
					lim = 16'h7FFF;
					uv = 16'hFFFF;
				end
				3: begin
					m = 1'b0;
					lim = rand16();
					uv = rand16();
				end
				default: begin
					m = ($urandom_range(0, 3) != 0);
					lim = ($urandom_range(0, 1) != 0) ? rand16() : (rand16() & 16'h03FF);
					uv = rand16();
				end
			endcase
			wait_idle();
			write_register(dps_pkg::CFG_SPEED_MODE, {15'd0, m});
			write_register(dps_pkg::CFG_SPEED_LIMIT, lim);
			write_register(dps_pkg::CFG_UV_CODE, uv);

			send_idle = (ph % 3 != 1);
			recv_idle = (ph % 4 != 3);
			// Pressure phase: the sender offers back to back while the receiver holds off
			// for a long stretch, so the block fills up and has to stall its input.
			if (ph == PRESSURE_PHASE) begin
				send_idle = 1'b0;
				long_hold = PRESSURE_HOLD;
			end
			repeat (ITEMS_PER_PHASE) send_command(random_command(), 1'b0, '0);
		end

		wait_idle();
		recv_idle = 1'b0;
		repeat (4) @(negedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
